>>> rtl/utf8ss_pkg.sv
package utf8ss_pkg;

  // Largest number of result words one input word can release.
  localparam int unsigned MaxOut = 4;

  // Width of the per-group word count, wide enough to hold MaxOut itself.
  localparam int unsigned CntW = $clog2(MaxOut + 1);

  // Width of the index that walks through one group.
  localparam int unsigned IdxW = $clog2(MaxOut);

  // Input word: one message byte and the end-of-message flag.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } utf8ss_in_t;

  // Result word as seen on the output channel.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_data;
    logic       out_last;
  } utf8ss_out_t;

  // Everything one input word releases, handed from the decoder to the serialiser.
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [CntW-1:0]        cnt;
    logic                   data;
    logic                   last;
  } utf8ss_group_t;

endpackage

>>> rtl/utf8ss_decode.sv
module utf8ss_decode (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  utf8ss_pkg::utf8ss_in_t  in_word,
  output utf8ss_pkg::utf8ss_group_t grp
);
  import utf8ss_pkg::*;

  // Pending sequence state.
  logic [1:0]  exp_r, exp_nxt;
  logic [1:0]  rcv_r, rcv_nxt;
  logic [20:0] cp_r, cp_nxt;
  logic [7:0]  held_r [3];
  logic [7:0]  held_nxt [3];

  logic [7:0]  b;
  logic        is_cont;
  logic        done;

  // Range checks on a completed code point, some by sequence length.
  function automatic logic cp_ok(input logic [1:0] tail, input logic [20:0] cp);
    logic ok;
    ok = 1'b1;
    if (tail == 2'd1 && cp < 21'h80) ok = 1'b0;
    if (tail == 2'd2 && cp < 21'h800) ok = 1'b0;
    if (tail == 2'd3 && cp < 21'h10000) ok = 1'b0;
    if (cp >= 21'hD800 && cp <= 21'hDFFF) ok = 1'b0;
    if (cp > 21'h10FFFF || cp == 21'hFFFE || cp == 21'hFFFF) ok = 1'b0;
    return ok;
  endfunction

  assign b       = in_word.in_byte;
  assign is_cont = (b[7:6] == 2'b10);
  assign done    = ({1'b0, rcv_r} + 3'd1) >= {1'b0, exp_r};

  // Decode one byte against the pending state.
  always_comb begin
    exp_nxt  = exp_r;
    rcv_nxt  = rcv_r;
    cp_nxt   = cp_r;
    held_nxt = held_r;
    grp      = '0;
    grp.data = 1'b1;

    if (exp_r != 2'd0 && is_cont) begin
      cp_nxt = {cp_r[14:0], b[5:0]};
      if (done) begin
        if (cp_ok(exp_r, cp_nxt)) begin
          grp.bytes[0] = held_r[0];
          grp.bytes[1] = (rcv_r >= 2'd1) ? held_r[1] : b;
          grp.bytes[2] = (rcv_r == 2'd2) ? held_r[2] : b;
          grp.bytes[3] = b;
          grp.cnt      = CntW'({1'b0, rcv_r} + 3'd2);
        end
        exp_nxt = 2'd0;
        rcv_nxt = 2'd0;
        cp_nxt  = '0;
      end else begin
        held_nxt[rcv_r + 2'd1] = b;
        rcv_nxt                = rcv_r + 2'd1;
      end
    end else begin
      // Anything else breaks a pending sequence and is then taken afresh.
      exp_nxt = 2'd0;
      rcv_nxt = 2'd0;
      cp_nxt  = '0;
      priority if (b == 8'd0) begin
        grp.cnt = '0;
      end else if (b[7] == 1'b0) begin
        grp.bytes[0] = b;
        grp.cnt      = CntW'(1);
      end else if (b[7:5] == 3'b110) begin
        exp_nxt     = 2'd1;
        cp_nxt      = {16'd0, b[4:0]};
        held_nxt[0] = b;
      end else if (b[7:4] == 4'b1110) begin
        exp_nxt     = 2'd2;
        cp_nxt      = {17'd0, b[3:0]};
        held_nxt[0] = b;
      end else if (b[7:3] == 5'b11110) begin
        exp_nxt     = 2'd3;
        cp_nxt      = {18'd0, b[2:0]};
        held_nxt[0] = b;
      end else begin
        grp.cnt = '0;
      end
    end

    // End of message: drop anything incomplete and always mark the end.
    if (in_word.in_last) begin
      exp_nxt = 2'd0;
      rcv_nxt = 2'd0;
      cp_nxt  = '0;
      grp.last = 1'b1;
      if (grp.cnt == '0) begin
        grp.bytes = '0;
        grp.cnt   = CntW'(1);
        grp.data  = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= 2'd0;
      rcv_r <= 2'd0;
      cp_r  <= '0;
    end else if (accept) begin
      exp_r <= exp_nxt;
      rcv_r <= rcv_nxt;
      cp_r  <= cp_nxt;
    end
  end

  // Held bytes are only read once written for the current sequence.
  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= held_nxt;
    end
  end

endmodule

>>> rtl/utf8ss_serialiser.sv
module utf8ss_serialiser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  utf8ss_pkg::utf8ss_group_t grp,
  output logic                      free,
  output logic                      out_valid,
  input  logic                      out_stall,
  output utf8ss_pkg::utf8ss_out_t   out_data
);
  import utf8ss_pkg::*;

  utf8ss_group_t   grp_r;
  logic            vld_r;
  logic [IdxW-1:0] idx_r;
  logic [IdxW-1:0] end_idx;
  logic            at_end;
  logic            out_fire;

  assign end_idx  = IdxW'(grp_r.cnt - CntW'(1));
  assign at_end   = (idx_r == end_idx);
  assign out_fire = vld_r && !out_stall;

  // The group register can take a new group once its final word leaves.
  assign free = !vld_r || (out_fire && at_end);

  assign out_valid         = vld_r;
  assign out_data.out_byte = grp_r.bytes[idx_r];
  assign out_data.has_data = grp_r.data;
  assign out_data.out_last = grp_r.last && at_end;

  // Word index and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else if (free) begin
      vld_r <= load;
      idx_r <= '0;
    end else if (out_fire) begin
      idx_r <= idx_r + IdxW'(1);
    end
  end

  // Group payload.
  always_ff @(posedge clk) begin
    if (free && load) begin
      grp_r <= grp;
    end
  end

endmodule

>>> rtl/utf8_stream_sanitizer.sv
// Channel | Direction | Ports                          | Word
// input   | in        | in_valid, in_stall, in_data    | one message byte and end flag
// output  | out       | out_valid, out_stall, out_data | one passed byte or end marker
//
// A byte is decoded in the cycle it is accepted and its results appear the next cycle.
// One byte is accepted per cycle while the output does not stall and each byte
// releases at most one result word; a byte completing a sequence of n bytes
// stalls the input until all n of its result words have left the group register.
// Reset clears the pending sequence and empties the result register.
// A stalled output holds its word and stalls the input once the group register is full.
module utf8_stream_sanitizer (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  utf8ss_pkg::utf8ss_in_t  in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output utf8ss_pkg::utf8ss_out_t out_data
);
  import utf8ss_pkg::*;

  utf8ss_group_t grp;
  logic          free;
  logic          in_fire;
  logic          load;

  assign in_stall = !free;
  assign in_fire  = in_valid && free;
  assign load     = in_fire && (grp.cnt != '0);

  // Byte decoder and pending sequence state.
  utf8ss_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_fire),
    .in_word (in_data),
    .grp     (grp)
  );

  // Result group register, one word per handshake.
  utf8ss_serialiser u_serialiser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .grp       (grp),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/utf8ss_checker.sv
module utf8ss_protocol_chk (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input utf8ss_pkg::utf8ss_in_t  in_data,
  input logic                    out_valid,
  input logic                    out_stall,
  input utf8ss_pkg::utf8ss_out_t out_data
);
  import utf8ss_pkg::*;

  // A stalled input word holds until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input word changed while stalled");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // An end marker carries no byte and always closes the message.
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_data |-> out_data.out_last && out_data.out_byte == 8'd0)
    else $error("malformed end marker");

  // A passed byte is never zero.
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.has_data |-> out_data.out_byte != 8'd0)
    else $error("zero byte passed");

  // With nothing waiting at the output the input is never held off.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind utf8_stream_sanitizer utf8ss_protocol_chk u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
